>>> hdl/bje_pkg.sv
// ----------------------------------------------------------------------------
// bje_pkg
// Types, constants and helpers shared by the escape-time engine.
// ----------------------------------------------------------------------------
package bje_pkg;

  localparam int IMAGE_SIZE_DEFAULT = 1024;
  localparam int COORD_W  = 10;
  localparam int ITER_W   = 10;
  localparam int STEP_W   = 28;
  localparam int FRAC_W   = 28;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [31:0] CONST_RE_RST  = 32'sd147639501;
  localparam logic signed [31:0] CONST_IM_RST  = -32'sd225485783;
  localparam logic signed [31:0] ORIGIN_RE_RST = -32'sd402653184;
  localparam logic signed [31:0] ORIGIN_IM_RST = -32'sd322122547;
  localparam logic [STEP_W-1:0]  STEP_RE_RST   = 28'd786432;
  localparam logic [STEP_W-1:0]  STEP_IM_RST   = 28'd629146;
  localparam logic [ITER_W-1:0]  MAX_ITER_RST  = 10'd50;

  // |z|^2 >= 4.0 in Q8.56
  localparam logic [64:0] ESC_LIM = 65'h1 << 58;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONST_RE  = 3'd0,
    REG_CONST_IM  = 3'd1,
    REG_ORIGIN_RE = 3'd2,
    REG_ORIGIN_IM = 3'd3,
    REG_STEP_RE   = 3'd4,
    REG_STEP_IM   = 3'd5,
    REG_MAX_ITER  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] const_re;
    logic signed [31:0] const_im;
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [STEP_W-1:0]  step_re;
    logic [STEP_W-1:0]  step_im;
    logic [ITER_W-1:0]  max_iter;
  } cfg_t;

  typedef struct packed {
    logic load;      // capture request, start mapping products
    logic map;       // form start point
    logic mul;       // register squares and cross product
    logic upd;       // step z and count
    logic out_load;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic esc_hit;
    logic at_limit;
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MAP  = 2'd1,
    S_MUL  = 2'd2,
    S_TEST = 2'd3
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sh007FFFFFFF;
    lo = 40'shFF80000000;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

>>> hdl/bje_cfg_regs.sv
// ----------------------------------------------------------------------------
// bje_cfg_regs
// Configuration register file, write-only, indexed writes.
// ----------------------------------------------------------------------------
module bje_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bje_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output bje_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.const_re  <= bje_pkg::CONST_RE_RST;
      cfg.const_im  <= bje_pkg::CONST_IM_RST;
      cfg.origin_re <= bje_pkg::ORIGIN_RE_RST;
      cfg.origin_im <= bje_pkg::ORIGIN_IM_RST;
      cfg.step_re   <= bje_pkg::STEP_RE_RST;
      cfg.step_im   <= bje_pkg::STEP_IM_RST;
      cfg.max_iter  <= bje_pkg::MAX_ITER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bje_pkg::REG_CONST_RE:  cfg.const_re  <= cfg_data;
        bje_pkg::REG_CONST_IM:  cfg.const_im  <= cfg_data;
        bje_pkg::REG_ORIGIN_RE: cfg.origin_re <= cfg_data;
        bje_pkg::REG_ORIGIN_IM: cfg.origin_im <= cfg_data;
        bje_pkg::REG_STEP_RE:   cfg.step_re   <= cfg_data[bje_pkg::STEP_W-1:0];
        bje_pkg::REG_STEP_IM:   cfg.step_im   <= cfg_data[bje_pkg::STEP_W-1:0];
        bje_pkg::REG_MAX_ITER:  cfg.max_iter  <= cfg_data[bje_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/bje_datapath.sv
// ----------------------------------------------------------------------------
// bje_datapath
// Coordinate mapping, Q4.28 burning-ship Julia iteration and result register.
// ----------------------------------------------------------------------------
module bje_datapath #(
  parameter int IMAGE_SIZE = bje_pkg::IMAGE_SIZE_DEFAULT
) (
  input  logic                        clk,
  input  bje_pkg::cfg_t               cfg,
  input  bje_pkg::cmd_t               cmd,
  input  logic [bje_pkg::COORD_W-1:0] pixel_col,
  input  logic [bje_pkg::COORD_W-1:0] pixel_row,
  output bje_pkg::status_t            status,
  output logic [bje_pkg::COORD_W-1:0] out_col,
  output logic [bje_pkg::COORD_W-1:0] out_row,
  output logic [bje_pkg::ITER_W-1:0]  iter_count,
  output logic                        escaped
);

  localparam int CW = bje_pkg::COORD_W;
  localparam int SW = bje_pkg::STEP_W;
  localparam int PW = CW + SW;
  localparam int FW = bje_pkg::FRAC_W;
  localparam int COORD_TOP = (1 << CW) - 1;
  localparam logic [CW-1:0] COORD_MAX =
    (IMAGE_SIZE - 1 > COORD_TOP) ? CW'(COORD_TOP) : CW'(IMAGE_SIZE - 1);

  logic [CW-1:0]           col_q, row_q;
  logic [PW-1:0]           prod_re, prod_im;
  logic signed [31:0]      zr, zi;
  logic [63:0]             sr, si, sx;
  logic [bje_pkg::ITER_W-1:0] count;

  logic [CW-1:0]           col_clamp, row_clamp;
  logic signed [39:0]      map_re, map_im;
  logic signed [63:0]      p_rr, p_ii, p_ri;
  logic [63:0]             abs_ri;
  logic [64:0]             mag;
  logic signed [39:0]      nr_w, ni_w;

  assign col_clamp = (pixel_col > COORD_MAX) ? COORD_MAX : pixel_col;
  assign row_clamp = (pixel_row > COORD_MAX) ? COORD_MAX : pixel_row;

  assign map_re = {{8{cfg.origin_re[31]}}, cfg.origin_re} + $signed({2'b00, prod_re});
  assign map_im = {{8{cfg.origin_im[31]}}, cfg.origin_im} + $signed({2'b00, prod_im});

  assign p_rr   = zr * zr;
  assign p_ii   = zi * zi;
  assign p_ri   = zr * zi;
  assign abs_ri = p_ri[63] ? 64'(-p_ri) : 64'(p_ri);

  assign mag = {1'b0, sr} + {1'b0, si};
  assign status.esc_hit  = (mag >= bje_pkg::ESC_LIM);
  assign status.at_limit = (count >= cfg.max_iter);

  // truncated Q4.28 terms; all three are non-negative
  assign nr_w = $signed({4'b0000, sr[63:FW]}) - $signed({4'b0000, si[63:FW]})
              + {{8{cfg.const_re[31]}}, cfg.const_re};
  assign ni_w = $signed({3'b000, sx[63:FW], 1'b0})
              + {{8{cfg.const_im[31]}}, cfg.const_im};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q   <= pixel_col;
      row_q   <= pixel_row;
      prod_re <= {{SW{1'b0}}, col_clamp} * {{CW{1'b0}}, cfg.step_re};
      prod_im <= {{SW{1'b0}}, row_clamp} * {{CW{1'b0}}, cfg.step_im};
    end
    if (cmd.map) begin
      zr    <= bje_pkg::sat32(map_re);
      zi    <= bje_pkg::sat32(map_im);
      count <= '0;
    end
    if (cmd.mul) begin
      sr <= 64'(p_rr);
      si <= 64'(p_ii);
      sx <= abs_ri;
    end
    if (cmd.upd) begin
      zr    <= bje_pkg::sat32(nr_w);
      zi    <= bje_pkg::sat32(ni_w);
      count <= count + 1'b1;
    end
    if (cmd.out_load) begin
      out_col    <= col_q;
      out_row    <= row_q;
      iter_count <= count;
      escaped    <= status.esc_hit;
    end
  end

endmodule

>>> hdl/bje_ctrl.sv
// ----------------------------------------------------------------------------
// bje_ctrl
// Sequencer for the escape-time loop and output register valid flag.
// ----------------------------------------------------------------------------
module bje_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  bje_pkg::status_t status,
  output bje_pkg::cmd_t    cmd
);

  bje_pkg::state_t state, state_next;
  logic            slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bje_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      bje_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = bje_pkg::S_MAP;
        end
      end
      bje_pkg::S_MAP: begin
        cmd.map    = 1'b1;
        state_next = bje_pkg::S_MUL;
      end
      bje_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = bje_pkg::S_TEST;
      end
      bje_pkg::S_TEST: begin
        // magnitude test wins over the count limit
        if (status.esc_hit || status.at_limit) begin
          if (slot_free) begin
            cmd.out_load = 1'b1;
            state_next   = bje_pkg::S_IDLE;
          end
        end else begin
          cmd.upd    = 1'b1;
          state_next = bje_pkg::S_MUL;
        end
      end
      default: state_next = bje_pkg::S_IDLE;
    endcase
  end

endmodule

>>> hdl/burning_julia_escape_time.sv
// ----------------------------------------------------------------------------
// burning_julia_escape_time
// Burning-ship Julia escape-time engine, one pixel request at a time.
// ----------------------------------------------------------------------------
// A request carries pixel_col/pixel_row on a valid/ready channel. The pixel
// is mapped to z = origin + coord * step (Q4.28) and iterated with
// z_re' = z_re^2 - z_im^2 + c_re, z_im' = 2|z_re z_im| + c_im until
// |z|^2 >= 4 or the count reaches max_iterations. The result (echoed
// coordinates, iter_count, escaped) leaves on a valid/ready channel.
// Each iteration is a multiply step (three 32x32 products) and a
// test/update step. in_ready is high only between requests. The result
// sits in an output register, so the next request is accepted while the
// previous result waits; a request that finishes while that register is
// still full holds until it is taken. Config writes (cfg_we/cfg_index/
// cfg_data) go straight into the config registers and must happen while
// the engine is idle. Synchronous reset loads the default view and
// constant, drops out_valid and returns to idle.
// ----------------------------------------------------------------------------
module burning_julia_escape_time #(
  parameter int IMAGE_SIZE = bje_pkg::IMAGE_SIZE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bje_pkg::COORD_W-1:0]   pixel_col,
  input  logic [bje_pkg::COORD_W-1:0]   pixel_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bje_pkg::COORD_W-1:0]   out_col,
  output logic [bje_pkg::COORD_W-1:0]   out_row,
  output logic [bje_pkg::ITER_W-1:0]    iter_count,
  output logic                          escaped,
  input  logic                          cfg_we,
  input  logic [bje_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  bje_pkg::cfg_t    cfg;
  bje_pkg::cmd_t    cmd;
  bje_pkg::status_t status;

  bje_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bje_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bje_datapath #(
    .IMAGE_SIZE (IMAGE_SIZE)
  ) u_dp (
    .clk        (clk),
    .cfg        (cfg),
    .cmd        (cmd),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .status     (status),
    .out_col    (out_col),
    .out_row    (out_row),
    .iter_count (iter_count),
    .escaped    (escaped)
  );

endmodule

>>> hdl/bje_checker.sv
// ----------------------------------------------------------------------------
// bje_checker
// Port-level checks for the escape-time engine, bound to the top level.
// ----------------------------------------------------------------------------
module bje_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bje_pkg::COORD_W-1:0] out_col,
  input logic [bje_pkg::COORD_W-1:0] out_row,
  input logic [bje_pkg::ITER_W-1:0]  iter_count,
  input logic                        escaped
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(out_row)
      && $stable(iter_count) && $stable(escaped))
    else $error("result changed while stalled");

  // one request in flight: the engine goes busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // no result can show up in the cycle after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result without iteration");

  // reset leaves the engine idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind burning_julia_escape_time bje_checker u_bje_checker (.*);

>>> tb/escape_time_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escape_time_checker
// Watches the request, result and register ports of the escape-time engine.
// It keeps its own copy of the view registers, predicts the count and the
// escape flag of every accepted request, and compares results in order.
// ----------------------------------------------------------------------------
module escape_time_checker #(
  parameter int IMAGE_SIZE = bje_pkg::IMAGE_SIZE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [bje_pkg::COORD_W-1:0]   pixel_col,
  input  logic [bje_pkg::COORD_W-1:0]   pixel_row,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [bje_pkg::COORD_W-1:0]   out_col,
  input  logic [bje_pkg::COORD_W-1:0]   out_row,
  input  logic [bje_pkg::ITER_W-1:0]    iter_count,
  input  logic                          escaped,
  input  logic                          cfg_we,
  input  logic [bje_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import bje_pkg::*;

  localparam logic [63:0] ESCAPE_MAG = 64'd4 << 56;  // 4.0 in Q8.56
  localparam longint INT32_HI = 64'sd2147483647;
  localparam longint INT32_LO = -64'sd2147483648;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [ITER_W-1:0]  count;
    logic               esc;
  } pixel_result_t;

  cfg_t          view;
  pixel_result_t awaited[$];
  int            mismatches = 0;

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > INT32_HI) return 32'sh7FFFFFFF;
    if (v < INT32_LO) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic logic signed [31:0] start_point(input logic [COORD_W-1:0] coord,
                                                     input logic signed [31:0] origin,
                                                     input logic [STEP_W-1:0] step);
    longint c;
    c = longint'(coord);
    // off-image pixels map onto the last one
    if (c > longint'(IMAGE_SIZE - 1)) c = longint'(IMAGE_SIZE - 1);
    return clip32(longint'(origin) + c * longint'(step));
  endfunction

  function automatic logic [63:0] mag_prod(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return (p < 0) ? 64'(-p) : 64'(p);
  endfunction

  function automatic pixel_result_t iterate_pixel(input logic [COORD_W-1:0] col,
                                                  input logic [COORD_W-1:0] row);
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic [63:0]        sq_re;
    logic [63:0]        sq_im;
    longint             sq_x;
    int                 count;
    bit                 done;
    pixel_result_t      r;
    zr = start_point(col, view.origin_re, view.step_re);
    zi = start_point(row, view.origin_im, view.step_im);
    count = 0;
    done = 1'b0;
    r.esc = 1'b0;
    // magnitude is tested before the count, so an escape at the limit still counts
    while (!done) begin
      sq_re = mag_prod(zr, zr);
      sq_im = mag_prod(zi, zi);
      if (sq_re + sq_im >= ESCAPE_MAG) begin
        r.esc = 1'b1;
        done = 1'b1;
      end else if (count >= view.max_iter) begin
        done = 1'b1;
      end else begin
        sq_x = longint'(mag_prod(zr, zi) >> FRAC_W);
        zr = clip32(longint'(sq_re >> FRAC_W) - longint'(sq_im >> FRAC_W)
                    + longint'($signed(view.const_re)));
        zi = clip32(2 * sq_x + longint'($signed(view.const_im)));
        count++;
      end
    end
    r.col = col;
    r.row = row;
    r.count = ITER_W'(count);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    pixel_result_t want;
    if (rst) begin
      view.const_re  = CONST_RE_RST;
      view.const_im  = CONST_IM_RST;
      view.origin_re = ORIGIN_RE_RST;
      view.origin_im = ORIGIN_IM_RST;
      view.step_re   = STEP_RE_RST;
      view.step_im   = STEP_IM_RST;
      view.max_iter  = MAX_ITER_RST;
      awaited.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CONST_RE:  view.const_re  = cfg_data;
          REG_CONST_IM:  view.const_im  = cfg_data;
          REG_ORIGIN_RE: view.origin_re = cfg_data;
          REG_ORIGIN_IM: view.origin_im = cfg_data;
          REG_STEP_RE:   view.step_re   = cfg_data[STEP_W-1:0];
          REG_STEP_IM:   view.step_im   = cfg_data[STEP_W-1:0];
          REG_MAX_ITER:  view.max_iter  = cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) awaited.push_back(iterate_pixel(pixel_col, pixel_row));
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result for pixel (%0d, %0d) with no request outstanding", out_col, out_row);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          check_field("out_col", int'(want.col), int'(out_col));
          check_field("out_row", int'(want.row), int'(out_row));
          check_field("iter_count", int'(want.count), int'(iter_count));
          check_field("escaped", int'(want.esc), int'(escaped));
        end
      end
    end
    pending <= awaited.size();
    fail_count <= mismatches;
  end

endmodule

>>> tb/burning_julia_escape_time_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// burning_julia_escape_time_tb
// Drives pixel requests through the escape-time engine under a series of
// views: directed corner, zero-limit, zero-step and saturation cases, then
// random views and pixels with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module burning_julia_escape_time_tb;
  import bje_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // unmapped, a write must be dropped
  localparam int PARK_CYCLES = 400;
  localparam int PIX_MAX = (1 << COORD_W) - 1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COORD_W-1:0]   pixel_col = '0;
  logic [COORD_W-1:0]   pixel_row = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COORD_W-1:0]   out_col;
  logic [COORD_W-1:0]   out_row;
  logic [ITER_W-1:0]    iter_count;
  logic                 escaped;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  int                   fail_count;
  int                   pending;
  bit                   idle_on = 1'b1;
  bit                   park_receiver = 1'b0;

  burning_julia_escape_time uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_col(pixel_col), .pixel_row(pixel_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_col(out_col), .out_row(out_row),
    .iter_count(iter_count), .escaped(escaped),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  escape_time_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_col(pixel_col), .pixel_row(pixel_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_col(out_col), .out_row(out_row),
    .iter_count(iter_count), .escaped(escaped),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // valid stays up across back-to-back requests; it only drops for a gap
  task automatic send_pixel(input int col, input int row);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_col <= COORD_W'(col);
    pixel_row <= COORD_W'(row);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_pixels(input int count);
    repeat (count) send_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic set_view(input logic [31:0] c_re, input logic [31:0] c_im,
                          input logic [31:0] o_re, input logic [31:0] o_im,
                          input logic [31:0] s_re, input logic [31:0] s_im,
                          input logic [31:0] iters);
    drain();
    write_reg(REG_CONST_RE, c_re);
    write_reg(REG_CONST_IM, c_im);
    write_reg(REG_ORIGIN_RE, o_re);
    write_reg(REG_ORIGIN_IM, o_im);
    write_reg(REG_STEP_RE, s_re);
    write_reg(REG_STEP_IM, s_im);
    write_reg(REG_MAX_ITER, iters);
    write_reg(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic random_view(input logic [31:0] iters);
    logic [31:0] c_re;
    logic [31:0] c_im;
    logic [31:0] o_re;
    logic [31:0] o_im;
    logic [31:0] s_re;
    logic [31:0] s_im;
    if ($urandom_range(0, 3) == 0) begin
      c_re = $urandom;
      c_im = $urandom;
    end else begin
      // constant within +/-1.5
      c_re = $urandom_range(0, 805306368) - 32'd402653184;
      c_im = $urandom_range(0, 805306368) - 32'd402653184;
    end
    if ($urandom_range(0, 3) == 0) begin
      o_re = $urandom;
      o_im = $urandom;
    end else begin
      o_re = $urandom_range(0, 671088640) - 32'd671088640;
      o_im = $urandom_range(0, 671088640) - 32'd671088640;
    end
    case ($urandom_range(0, 4))
      0: begin
        s_re = $urandom;
        s_im = $urandom;
      end
      1: begin
        s_re = $urandom_range(1, 28'hFFFFFFF);
        s_im = $urandom_range(1, 28'hFFFFFFF);
      end
      default: begin
        s_re = $urandom_range(131072, 1048576);
        s_im = $urandom_range(131072, 1048576);
      end
    endcase
    set_view(c_re, c_im, o_re, o_im, s_re, s_im, iters);
  endtask

  initial begin : result_sink
    int stall;
    wait (!rst);
    forever begin
      if (park_receiver) begin
        stall = PARK_CYCLES;
        park_receiver = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, 10) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [31:0] iters;
    int          count;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset view: corners and the middle
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(0, PIX_MAX);
    send_pixel(PIX_MAX, 0);
    send_pixel(512, 512);
    send_pixel(341, 682);

    // c = 0 over a small disc: orbit collapses, runs to the largest limit
    set_view(32'd0, 32'd0, -32'sd134217728, -32'sd134217728, 32'd65536, 32'd65536, 32'd1023);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);

    // zero limit; upper data bits set on step and limit must be ignored
    set_view(CONST_RE_RST, CONST_IM_RST, ORIGIN_RE_RST, ORIGIN_IM_RST,
             32'hF01E8480, 32'hFFFFFFFF, 32'hFFFFFC00);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, 0);
    send_pixel(0, PIX_MAX);

    // zero step: every pixel lands on the origin
    set_view(CONST_RE_RST, CONST_IM_RST, -32'sd134217728, -32'sd80530636, 32'd0, 32'd0, 32'd20);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);

    // start point at both ends of the range, clipped at the top
    set_view(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
             32'h0FFFFFFF, 32'h0FFFFFFF, 32'd1023);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);

    // extreme constants drive the next z into clipping
    set_view(32'h7FFFFFFF, 32'h80000000, 32'd0, 32'd0, 32'd262144, 32'd262144, 32'd10);
    send_pixel(PIX_MAX, 0);
    send_pixel(0, 0);
    set_view(32'h80000000, 32'h7FFFFFFF, 32'd0, 32'd0, 32'd262144, 32'd262144, 32'd10);
    send_pixel(0, PIX_MAX);
    send_pixel(PIX_MAX, PIX_MAX);

    // receiver parks while requests keep coming, so the input backs up
    random_view(32'd16);
    park_receiver = 1'b1;
    idle_on = 1'b0;
    random_pixels(8);
    idle_on = 1'b1;

    for (int p = 0; p < 11; p++) begin
      iters = $urandom_range(1, 64);
      count = 104;
      if (p == 3) iters = 0;
      if (p == 5) begin
        iters = 1023;
        count = 6;
      end
      random_view(iters);
      idle_on = (p != 7);
      random_pixels(count);
    end
    idle_on = 1'b1;

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[burning_julia_escape_time] OK");
    end else begin
      $display("[burning_julia_escape_time] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("[burning_julia_escape_time] ERROR");
    $finish;
  end

endmodule
